[rtl/sjpc_pkg.sv]
package sjpc_pkg;

    localparam int POSITION_WIDTH_DEF = 16;
    localparam int TIMER_WIDTH_DEF    = 8;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int PRESET_WIDTH    = 16;
    localparam int SETTING_WIDTH   = 8;
    localparam int SEL_WIDTH       = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESET_0    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESET_1    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESET_2    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_JOG_STEPS   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEBOUNCE    = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEP_PERIOD = 3'd5;

    localparam logic signed [PRESET_WIDTH-1:0] PRESET_0_RST    = 16'sd72;
    localparam logic signed [PRESET_WIDTH-1:0] PRESET_1_RST    = 16'sd144;
    localparam logic signed [PRESET_WIDTH-1:0] PRESET_2_RST    = 16'sd250;
    localparam logic [SETTING_WIDTH-1:0]       JOG_STEPS_RST   = 8'd10;
    localparam logic [SETTING_WIDTH-1:0]       DEBOUNCE_RST    = 8'd5;
    localparam logic [SETTING_WIDTH-1:0]       STEP_PERIOD_RST = 8'd11;

    localparam logic [SEL_WIDTH-1:0] PRESET_LAST = 2'd2;

    typedef enum logic [1:0] {
        REQ_ENC_A  = 2'd0,
        REQ_ENC_B  = 2'd1,
        REQ_BUTTON = 2'd2,
        REQ_TICK   = 2'd3
    } t_req;

    typedef enum logic {
        BTN_IDLE    = 1'b0,
        BTN_PENDING = 1'b1
    } t_btn_phase;

endpackage

[rtl/sjpc_preset_move.sv]
module sjpc_preset_move #(
    parameter int POSITION_WIDTH = sjpc_pkg::POSITION_WIDTH_DEF
) (
    input  logic [sjpc_pkg::SEL_WIDTH-1:0]           i_sel,
    input  logic signed [sjpc_pkg::PRESET_WIDTH-1:0] i_preset_0,
    input  logic signed [sjpc_pkg::PRESET_WIDTH-1:0] i_preset_1,
    input  logic signed [sjpc_pkg::PRESET_WIDTH-1:0] i_preset_2,
    input  logic signed [POSITION_WIDTH-1:0]         i_position,
    output logic                                     o_dir,
    output logic [POSITION_WIDTH-1:0]                o_steps
);
    import sjpc_pkg::*;

    localparam int EXT_W = (POSITION_WIDTH > PRESET_WIDTH ? POSITION_WIDTH : PRESET_WIDTH) + 1;

    logic signed [PRESET_WIDTH-1:0]   target;
    logic signed [EXT_W-1:0]          target_ext;
    logic signed [EXT_W-1:0]          pos_max_ext;
    logic signed [EXT_W-1:0]          pos_min_ext;
    logic signed [POSITION_WIDTH-1:0] target_clamp;
    logic signed [POSITION_WIDTH:0]   diff;
    logic [POSITION_WIDTH:0]          diff_abs;

    always_comb begin
        unique case (i_sel)
            2'd1:    target = i_preset_1;
            2'd2:    target = i_preset_2;
            default: target = i_preset_0;
        endcase
    end

    assign target_ext  = EXT_W'(target);
    assign pos_max_ext = EXT_W'({1'b0, {(POSITION_WIDTH-1){1'b1}}});
    assign pos_min_ext = ~pos_max_ext;

    always_comb begin
        priority if (target_ext > pos_max_ext) begin
            target_clamp = pos_max_ext[POSITION_WIDTH-1:0];
        end else if (target_ext < pos_min_ext) begin
            target_clamp = pos_min_ext[POSITION_WIDTH-1:0];
        end else begin
            target_clamp = target_ext[POSITION_WIDTH-1:0];
        end
    end

    assign diff     = (POSITION_WIDTH+1)'(target_clamp) - (POSITION_WIDTH+1)'(i_position);
    assign diff_abs = diff[POSITION_WIDTH] ? -diff : diff;
    assign o_dir    = !diff[POSITION_WIDTH] && (diff != '0);
    assign o_steps  = diff_abs[POSITION_WIDTH-1:0];

endmodule

[rtl/stepper_jog_preset_controller.sv]
// An accepted input beat's result beat is registered and is valid in the cycle after the beat.
// Throughput: one item per cycle unless a held result stalls on i_ready low; the whole
// event update is one pass of logic from the state registers into the state and result registers.
// Reset (i_rst_n low, synchronous): state cleared, prev A level high,
// configuration back to its defaults, no result pending.
module stepper_jog_preset_controller #(
    parameter int POSITION_WIDTH = sjpc_pkg::POSITION_WIDTH_DEF,
    parameter int TIMER_WIDTH    = sjpc_pkg::TIMER_WIDTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [sjpc_pkg::CFG_INDEX_WIDTH-1:0]     i_cfg_index,
    input  logic [sjpc_pkg::CFG_DATA_WIDTH-1:0]      i_cfg_data,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [1:0]                               i_req_type,
    input  logic                                     i_enc_a,
    input  logic                                     i_enc_b,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic                                     o_step_pulse,
    output logic                                     o_step_dir,
    output logic signed [POSITION_WIDTH-1:0]         o_position,
    output logic                                     o_moving,
    output logic [sjpc_pkg::SEL_WIDTH-1:0]           o_preset_index
);
    import sjpc_pkg::*;

    localparam logic signed [POSITION_WIDTH-1:0] POS_MAX = {1'b0, {(POSITION_WIDTH-1){1'b1}}};
    localparam logic signed [POSITION_WIDTH-1:0] POS_MIN = ~POS_MAX;

    // configuration
    logic signed [PRESET_WIDTH-1:0] r_preset_0, r_preset_1, r_preset_2;
    logic [SETTING_WIDTH-1:0]       r_jog_steps, r_debounce, r_step_period;

    // controller state
    logic signed [POSITION_WIDTH-1:0] r_position, n_position;
    logic [POSITION_WIDTH-1:0]        r_steps_left, n_steps_left;
    logic                             r_dir, n_dir;
    logic [TIMER_WIDTH-1:0]           r_tick_wait, n_tick_wait;
    logic [TIMER_WIDTH-1:0]           r_lock_a, n_lock_a;
    logic [TIMER_WIDTH-1:0]           r_lock_b, n_lock_b;
    logic [TIMER_WIDTH-1:0]           r_lock_btn, n_lock_btn;
    t_btn_phase                       r_phase, n_phase;
    logic [SEL_WIDTH-1:0]             r_sel, n_sel;
    logic                             r_prev_a, n_prev_a;
    logic                             r_out_valid, n_out_valid;
    logic                             r_pulse, n_pulse;

    logic                   in_beat;
    logic [TIMER_WIDTH-1:0] lock_load;
    logic [TIMER_WIDTH-1:0] period_reload;
    logic [TIMER_WIDTH-1:0] tw;
    logic [SEL_WIDTH-1:0]   sel_adv;
    logic [SEL_WIDTH-1:0]   move_sel;
    logic                   mv_dir;
    logic [POSITION_WIDTH-1:0] mv_steps;
    t_req                   req;

    assign req           = t_req'(i_req_type);
    assign o_ready       = !r_out_valid || i_ready;
    assign in_beat       = i_valid && o_ready;
    assign o_cfg_ready   = 1'b1;
    assign lock_load     = TIMER_WIDTH'(r_debounce);
    assign period_reload = (r_step_period == '0) ? '0 : TIMER_WIDTH'(r_step_period - 8'd1);
    assign sel_adv       = (r_sel >= PRESET_LAST) ? '0 : r_sel + 2'd1;
    assign move_sel      = (req == REQ_BUTTON) ? sel_adv : r_sel;

    sjpc_preset_move #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_move (
        .i_sel      (move_sel),
        .i_preset_0 (r_preset_0),
        .i_preset_1 (r_preset_1),
        .i_preset_2 (r_preset_2),
        .i_position (r_position),
        .o_dir      (mv_dir),
        .o_steps    (mv_steps)
    );

    always_comb begin
        n_position   = r_position;
        n_steps_left = r_steps_left;
        n_dir        = r_dir;
        n_tick_wait  = r_tick_wait;
        n_lock_a     = r_lock_a;
        n_lock_b     = r_lock_b;
        n_lock_btn   = r_lock_btn;
        n_phase      = r_phase;
        n_sel        = r_sel;
        n_prev_a     = r_prev_a;
        n_pulse      = r_pulse;
        tw           = '0;
        n_out_valid  = r_out_valid && !i_ready;
        if (in_beat) begin
            n_out_valid = 1'b1;
            n_pulse     = 1'b0;
            unique case (req)
                REQ_ENC_A: begin
                    if (r_lock_a == '0) begin
                        n_lock_a = lock_load;
                        if (r_steps_left == '0) begin
                            if (i_enc_a != r_prev_a && i_enc_a && !i_enc_b) begin
                                n_steps_left = POSITION_WIDTH'(r_jog_steps);
                                n_dir        = 1'b1;
                            end
                            n_prev_a = i_enc_a;
                        end
                    end
                end
                REQ_ENC_B: begin
                    if (r_lock_b == '0) begin
                        n_lock_b = lock_load;
                        if (r_steps_left == '0 && !i_enc_a && i_enc_b) begin
                            n_steps_left = POSITION_WIDTH'(r_jog_steps);
                            n_dir        = 1'b0;
                        end
                    end
                end
                REQ_BUTTON: begin
                    if (r_lock_btn == '0) begin
                        n_sel      = sel_adv;
                        n_lock_btn = lock_load;
                        n_phase    = BTN_PENDING;
                        if (lock_load == '0) begin
                            n_steps_left = mv_steps;
                            n_dir        = mv_dir;
                            n_phase      = BTN_IDLE;
                        end
                    end
                end
                REQ_TICK: begin
                    if (r_lock_a != '0) n_lock_a = r_lock_a - 1'b1;
                    if (r_lock_b != '0) n_lock_b = r_lock_b - 1'b1;
                    if (r_lock_btn != '0) begin
                        n_lock_btn = r_lock_btn - 1'b1;
                        if (n_lock_btn == '0 && r_phase == BTN_PENDING) begin
                            n_steps_left = mv_steps;
                            n_dir        = mv_dir;
                            n_phase      = BTN_IDLE;
                        end
                    end
                    tw = (r_tick_wait != '0) ? r_tick_wait - 1'b1 : '0;
                    if (n_steps_left != '0 && tw == '0) begin
                        n_steps_left = n_steps_left - 1'b1;
                        tw           = period_reload;
                        if (n_dir) begin
                            if (r_position != POS_MAX) begin
                                n_position = r_position + 1'b1;
                                n_pulse    = 1'b1;
                            end
                        end else begin
                            if (r_position != POS_MIN) begin
                                n_position = r_position - 1'b1;
                                n_pulse    = 1'b1;
                            end
                        end
                    end
                    n_tick_wait = tw;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position   <= '0;
            r_steps_left <= '0;
            r_dir        <= 1'b0;
            r_tick_wait  <= '0;
            r_lock_a     <= '0;
            r_lock_b     <= '0;
            r_lock_btn   <= '0;
            r_phase      <= BTN_IDLE;
            r_sel        <= '0;
            r_prev_a     <= 1'b1;
            r_out_valid  <= 1'b0;
            r_pulse      <= 1'b0;
        end else begin
            r_position   <= n_position;
            r_steps_left <= n_steps_left;
            r_dir        <= n_dir;
            r_tick_wait  <= n_tick_wait;
            r_lock_a     <= n_lock_a;
            r_lock_b     <= n_lock_b;
            r_lock_btn   <= n_lock_btn;
            r_phase      <= n_phase;
            r_sel        <= n_sel;
            r_prev_a     <= n_prev_a;
            r_out_valid  <= n_out_valid;
            r_pulse      <= n_pulse;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preset_0    <= PRESET_0_RST;
            r_preset_1    <= PRESET_1_RST;
            r_preset_2    <= PRESET_2_RST;
            r_jog_steps   <= JOG_STEPS_RST;
            r_debounce    <= DEBOUNCE_RST;
            r_step_period <= STEP_PERIOD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PRESET_0:    r_preset_0    <= i_cfg_data;
                CFG_PRESET_1:    r_preset_1    <= i_cfg_data;
                CFG_PRESET_2:    r_preset_2    <= i_cfg_data;
                CFG_JOG_STEPS:   r_jog_steps   <= i_cfg_data[SETTING_WIDTH-1:0];
                CFG_DEBOUNCE:    r_debounce    <= i_cfg_data[SETTING_WIDTH-1:0];
                CFG_STEP_PERIOD: r_step_period <= i_cfg_data[SETTING_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // state only advances on a beat that finds the result slot free or being taken,
    // so the state registers always hold the last item's result
    assign o_valid        = r_out_valid;
    assign o_step_pulse   = r_pulse;
    assign o_step_dir     = r_dir;
    assign o_position     = r_position;
    assign o_moving       = (r_steps_left != '0);
    assign o_preset_index = r_sel;

endmodule
